/* rtl/mlcd_fbr_pkg.sv */
// shared constants, codes and types of the mono lcd framebuffer refresh core
package mlcd_fbr_pkg;

  // display geometry
  localparam int unsigned PAGE_COUNT       = 8;
  localparam int unsigned COLUMNS_PER_CHIP = 64;

  // pixel store: 8 pages of 128 bytes
  localparam int unsigned STORE_DEPTH = 1024;
  localparam int unsigned ADDR_W      = 10;
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned PAGE_W      = 3;
  localparam int unsigned SLOT_W      = 7;
  localparam int unsigned COL_W       = 7;

  // input command codes
  localparam logic [1:0] CMD_PLOT    = 2'd0;
  localparam logic [1:0] CMD_CLEAR   = 2'd1;
  localparam logic [1:0] CMD_START   = 2'd2;
  localparam logic [1:0] CMD_ADVANCE = 2'd3;

  // display controller command words
  localparam logic [BYTE_W-1:0] LCD_SET_PAGE   = 8'hB8;
  localparam logic [BYTE_W-1:0] LCD_SET_ORIGIN = 8'h40;

  // what the second pipeline stage holds
  localparam logic [1:0] KIND_NONE = 2'd0;
  localparam logic [1:0] KIND_PLOT = 2'd1;
  localparam logic [1:0] KIND_WORD = 2'd2;

  // current word of the refresh sequence
  typedef struct packed {
    logic              active;
    logic              chip;
    logic              is_data;
    logic [BYTE_W-1:0] cmd_byte;
    logic              done;
    logic [ADDR_W-1:0] addr;
  } seq_t;

endpackage

/* rtl/mlcd_fbr_ram.sv */
// generic single-write, single-read synchronous ram with registered read data
module mlcd_fbr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/mlcd_fbr_seq.sv */
// refresh sequencer: chip, page and slot counters and the word they select
module mlcd_fbr_seq (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic                step_i,
  output mlcd_fbr_pkg::seq_t  seq_o
);

  logic                                  active_q, active_d;
  logic                                  chip_q, chip_d;
  logic [mlcd_fbr_pkg::PAGE_W-1:0]       page_q, page_d;
  logic [mlcd_fbr_pkg::SLOT_W-1:0]       slot_q, slot_d;
  logic [mlcd_fbr_pkg::COL_W-1:0]        col;
  logic                                  last_slot;
  logic                                  last_page;

  assign last_slot = (slot_q == mlcd_fbr_pkg::SLOT_W'(mlcd_fbr_pkg::COLUMNS_PER_CHIP + 1));
  assign last_page = (page_q == mlcd_fbr_pkg::PAGE_W'(mlcd_fbr_pkg::PAGE_COUNT - 1));

  // slots 0 and 1 are command words, data columns start at slot 2
  assign col = slot_q - mlcd_fbr_pkg::COL_W'(2);

  always_comb begin
    seq_o.active  = active_q;
    seq_o.chip    = chip_q;
    seq_o.is_data = (slot_q >= mlcd_fbr_pkg::SLOT_W'(2));
    if (slot_q == '0) begin
      seq_o.cmd_byte = mlcd_fbr_pkg::LCD_SET_PAGE
                     | {{(mlcd_fbr_pkg::BYTE_W - mlcd_fbr_pkg::PAGE_W){1'b0}}, page_q};
    end else begin
      seq_o.cmd_byte = mlcd_fbr_pkg::LCD_SET_ORIGIN;
    end
    seq_o.done = chip_q && last_page && last_slot;
    seq_o.addr = {page_q, 7'd0}
               + {3'd0, chip_q, 6'd0}
               + {{(mlcd_fbr_pkg::ADDR_W - mlcd_fbr_pkg::COL_W){1'b0}}, col};
  end

  always_comb begin
    active_d = active_q;
    chip_d   = chip_q;
    page_d   = page_q;
    slot_d   = slot_q;
    if (start_i) begin
      active_d = 1'b1;
      chip_d   = 1'b0;
      page_d   = '0;
      slot_d   = '0;
    end else if (step_i) begin
      if (last_slot) begin
        slot_d = '0;
        if (last_page) begin
          page_d = '0;
          if (chip_q) begin
            active_d = 1'b0;
            chip_d   = 1'b0;
          end else begin
            chip_d = 1'b1;
          end
        end else begin
          page_d = page_q + 1'b1;
        end
      end else begin
        slot_d = slot_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      chip_q   <= 1'b0;
      page_q   <= '0;
      slot_q   <= '0;
    end else begin
      active_q <= active_d;
      chip_q   <= chip_d;
      page_q   <= page_d;
      slot_q   <= slot_d;
    end
  end

endmodule

/* rtl/mono_lcd_framebuffer_refresh_core.sv */
// top level: 128x64 page-organised framebuffer with a two-chip refresh word stream
// One input transfer is taken per cycle. A plot is a read-modify-write of one byte of
// the 1024x8 pixel ram (read in the accept cycle, written back in the next, with a
// forwarding path so that back-to-back plots and refresh reads of the same byte see
// the newest data). A refresh advance reads one byte and yields one output transfer
// by way of the stage-two and output registers; start and out-of-range plots produce
// nothing, and an advance while no refresh runs is dropped. A clear, and reset, run
// a clearing pass that writes one byte a cycle: s_axis_tready stays low until all
// 1024 bytes are written. Input is also held off while a finished word waits in the
// output register and the next one is already read.
module mono_lcd_framebuffer_refresh_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // cmd [1:0], x_coord [9:2], y_coord [17:10], zero pad
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // bus_byte [7:0]
  output logic [1:0]  m_axis_tuser,   // chip_select [0], is_data [1]
  output logic        m_axis_tlast    // frame_done
);

  localparam int unsigned AW = mlcd_fbr_pkg::ADDR_W;
  localparam int unsigned BW = mlcd_fbr_pkg::BYTE_W;

  logic [1:0]    in_cmd;
  logic [7:0]    in_x;
  logic [7:0]    in_y;
  logic          accept;
  logic [5:0]    y_flip;
  logic          plot_ok;
  logic [AW-1:0] plot_addr;
  logic [BW-1:0] plot_mask;
  logic          is_word;

  mlcd_fbr_pkg::seq_t seq;

  // ram ports
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [BW-1:0] ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [BW-1:0] ram_rdata;

  // clearing pass
  logic          clr_active_q, clr_active_d;
  logic [AW-1:0] clr_addr_q, clr_addr_d;

  // second stage
  logic          s2_valid_q;
  logic [1:0]    s2_kind_q;
  logic [AW-1:0] s2_addr_q;
  logic [BW-1:0] s2_mask_q;
  logic          s2_chip_q;
  logic          s2_is_data_q;
  logic [BW-1:0] s2_byte_q;
  logic          s2_done_q;
  logic          s2_stall;
  logic [BW-1:0] s2_data;

  // same-cycle write forwarding
  logic          fwd_hit_q;
  logic [BW-1:0] fwd_data_q;

  // output register
  logic          o_valid_q;
  logic [BW-1:0] o_byte_q;
  logic          o_chip_q;
  logic          o_is_data_q;
  logic          o_done_q;

  assign in_cmd = s_axis_tdata[1:0];
  assign in_x   = s_axis_tdata[9:2];
  assign in_y   = s_axis_tdata[17:10];

  // y is flipped to 63-y
  assign y_flip    = ~in_y[5:0];
  assign plot_ok   = !in_x[7] && (in_y[7:6] == 2'b00);
  assign plot_addr = {y_flip[5:3], in_x[6:0]};
  assign plot_mask = BW'(1) << y_flip[2:0];

  assign s2_stall      = s2_valid_q && (s2_kind_q == mlcd_fbr_pkg::KIND_WORD)
                         && o_valid_q && !m_axis_tready;
  assign s_axis_tready = !clr_active_q && !s2_stall;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign is_word       = (in_cmd == mlcd_fbr_pkg::CMD_ADVANCE) && seq.active;

  mlcd_fbr_seq u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (accept && (in_cmd == mlcd_fbr_pkg::CMD_START)),
    .step_i  (accept && is_word),
    .seq_o   (seq)
  );

  assign s2_data = fwd_hit_q ? fwd_data_q : ram_rdata;

  // clearing pass has the write port; otherwise the plot write-back of stage two
  always_comb begin
    if (clr_active_q) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr_q;
      ram_wdata = '0;
    end else begin
      ram_we    = s2_valid_q && (s2_kind_q == mlcd_fbr_pkg::KIND_PLOT);
      ram_waddr = s2_addr_q;
      ram_wdata = s2_data | s2_mask_q;
    end
  end

  assign ram_raddr = (in_cmd == mlcd_fbr_pkg::CMD_PLOT) ? plot_addr : seq.addr;

  mlcd_fbr_ram #(
    .WIDTH (BW),
    .DEPTH (mlcd_fbr_pkg::STORE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (accept),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    clr_active_d = clr_active_q;
    clr_addr_d   = clr_addr_q;
    if (clr_active_q) begin
      clr_addr_d = clr_addr_q + 1'b1;
      if (clr_addr_q == AW'(mlcd_fbr_pkg::STORE_DEPTH - 1)) begin
        clr_active_d = 1'b0;
      end
    end else if (accept && (in_cmd == mlcd_fbr_pkg::CMD_CLEAR)) begin
      clr_active_d = 1'b1;
      clr_addr_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_active_q <= 1'b1;
      clr_addr_q   <= '0;
      s2_valid_q   <= 1'b0;
      s2_kind_q    <= mlcd_fbr_pkg::KIND_NONE;
      o_valid_q    <= 1'b0;
    end else begin
      clr_active_q <= clr_active_d;
      clr_addr_q   <= clr_addr_d;
      if (!s2_stall) begin
        s2_valid_q <= accept;
        if (accept && (in_cmd == mlcd_fbr_pkg::CMD_PLOT) && plot_ok) begin
          s2_kind_q <= mlcd_fbr_pkg::KIND_PLOT;
        end else if (accept && is_word) begin
          s2_kind_q <= mlcd_fbr_pkg::KIND_WORD;
        end else begin
          s2_kind_q <= mlcd_fbr_pkg::KIND_NONE;
        end
      end
      if (s2_valid_q && (s2_kind_q == mlcd_fbr_pkg::KIND_WORD) && !s2_stall) begin
        o_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        o_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s2_addr_q    <= plot_addr;
      s2_mask_q    <= plot_mask;
      s2_chip_q    <= seq.chip;
      s2_is_data_q <= seq.is_data;
      s2_byte_q    <= seq.cmd_byte;
      s2_done_q    <= seq.done;
      // a write landing in the read cycle is not seen by the ram read
      fwd_hit_q    <= ram_we && (ram_waddr == ram_raddr);
      fwd_data_q   <= ram_wdata;
    end
    if (s2_valid_q && (s2_kind_q == mlcd_fbr_pkg::KIND_WORD) && !s2_stall) begin
      o_byte_q    <= s2_is_data_q ? s2_data : s2_byte_q;
      o_chip_q    <= s2_chip_q;
      o_is_data_q <= s2_is_data_q;
      o_done_q    <= s2_done_q;
    end
  end

  assign m_axis_tvalid = o_valid_q;
  assign m_axis_tdata  = o_byte_q;
  assign m_axis_tuser  = {o_is_data_q, o_chip_q};
  assign m_axis_tlast  = o_done_q;

endmodule

/* rtl/mlcd_fbr_chk.sv */
// port-level checker for the framebuffer refresh core and its bind
module mlcd_fbr_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [23:0] s_axis_tdata,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [7:0]  m_axis_tdata,
  input logic [1:0]  m_axis_tuser,
  input logic        m_axis_tlast
);

  // a stalled output transfer holds its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("output payload changed while stalled");

  // the frame ends on a data byte of the right controller
  a_last_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tuser[1] && m_axis_tuser[0])
    else $error("frame end not on a right-half data byte");

  // command words are set-page or set-origin only
  a_cmd_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[1] |->
      (m_axis_tdata[7:3] == 5'b10111) || (m_axis_tdata == 8'h40))
    else $error("bad controller command word");

  // the clearing pass after reset holds off input
  a_reset_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(rst_ni) |-> !s_axis_tready)
    else $error("input taken during clearing pass after reset");

  // a clear transfer starts the clearing pass at once
  a_clear_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && (s_axis_tdata[1:0] == 2'd1) |=> !s_axis_tready)
    else $error("input taken right after a clear");

endmodule

bind mono_lcd_framebuffer_refresh_core mlcd_fbr_chk u_mlcd_fbr_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);
